@@ hw/rtl/cubic_smoothstep_profile_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cubic smoothstep profile.
// Each macro expects clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef CUBIC_SMOOTHSTEP_PROFILE_DEFINES_SVH
`define CUBIC_SMOOTHSTEP_PROFILE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CSS_ASSERT_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSS_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/css_pkg.sv @@
// ----------------------------------------------------------------------------
// css_pkg
// Shared types, constants and the saturation helper of the smoothstep profile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package css_pkg;

	// Quotient bits produced by each long divider.
	localparam int Q_W = 32;
	// Restoring steps done in each divider stage.
	localparam int DIV_STEPS = 2;
	// One in unsigned Q1.31.
	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 2'd2;

	// Region flags that travel with every request.
	typedef struct packed {
		logic bad;
		logic below;
		logic above;
		logic neg;
	} ctl_t;

	// Applies a sign to a magnitude and clamps to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic neg, input logic ovf,
			input logic [31:0] mag);
		logic [31:0] res;
		if (neg) begin
			if (ovf || (mag > ONE_Q31)) res = 32'h8000_0000;
			else res = ~mag + 32'd1;
		end else begin
			if (ovf || mag[31]) res = 32'h7FFF_FFFF;
			else res = mag;
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/css_div_pipe.sv @@
// ----------------------------------------------------------------------------
// css_div_pipe
// Pipelined restoring divider. The dividend is {rem, lo} with rem below den;
// each stage resolves DIV_STEPS quotient bits. Side data rides along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module css_div_pipe import css_pkg::*; #(
	parameter int DEN_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DEN_W-1:0]  in_rem,
	input  logic [Q_W-1:0]    in_lo,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [Q_W-1:0]    out_quo,
	output logic [SIDE_W-1:0] out_side
);

	localparam int NSTG = Q_W / DIV_STEPS;

	// Entry 0 is the input; entry g+1 is the register of stage g.
	logic              valid_s [NSTG+1];
	logic [DEN_W-1:0]  rem_s   [NSTG+1];
	logic [Q_W-1:0]    word_s  [NSTG+1];
	logic [DEN_W-1:0]  den_s   [NSTG+1];
	logic [SIDE_W-1:0] side_s  [NSTG+1];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = in_rem;
	assign word_s[0]  = in_lo;
	assign den_s[0]   = in_den;
	assign side_s[0]  = in_side;

	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		logic [DEN_W-1:0] rem_nx;
		logic [Q_W-1:0]   word_nx;

		// Shift in dividend bits at the top, quotient bits at the bottom.
		always_comb begin
			logic [DEN_W:0]   t;
			logic [DEN_W-1:0] r;
			logic [Q_W-1:0]   w;
			r = rem_s[g];
			w = word_s[g];
			for (int k = 0; k < DIV_STEPS; k++) begin
				t = {r, w[Q_W-1]};
				w = {w[Q_W-2:0], 1'b0};
				if (t >= {1'b0, den_s[g]}) begin
					t = t - {1'b0, den_s[g]};
					w[0] = 1'b1;
				end
				r = t[DEN_W-1:0];
			end
			rem_nx  = r;
			word_nx = w;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (en) begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1]  <= rem_nx;
				word_s[g+1] <= word_nx;
				den_s[g+1]  <= den_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = valid_s[NSTG];
	assign out_quo   = word_s[NSTG];
	assign out_side  = side_s[NSTG];

endmodule

@@ hw/rtl/css_poly.sv @@
// ----------------------------------------------------------------------------
// css_poly
// Four stages of multipliers that turn u into the value magnitude and the
// numerators of the slope and curvature divisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module css_poly import css_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] u,
	input  logic [31:0] span,
	input  logic [31:0] mag,
	input  ctl_t        in_ctl,
	input  logic [31:0] in_amp,
	output logic        out_valid,
	output ctl_t        out_ctl,
	output logic [31:0] out_amp,
	output logic [31:0] val_mag,
	output logic        e_neg,
	output logic [31:0] s_rem,
	output logic [31:0] s_lo,
	output logic        ovf_s,
	output logic [31:0] s_den,
	output logic [63:0] c_rem,
	output logic [31:0] c_lo,
	output logic        ovf_c,
	output logic [63:0] c_den
);

	// Slope numerator drops 31-FRAC_BITS bits before dividing by the span.
	localparam int K    = 31 - FRAC_BITS;
	localparam int PS_W = 32 + FRAC_BITS;
	// Curvature numerator scales by 2^(2*FRAC_BITS-30) before dividing by span^2.
	localparam int CSH  = 2 * FRAC_BITS - 30;
	localparam int LSH  = (CSH > 0) ? CSH : 0;
	localparam int RSH  = (CSH < 0) ? -CSH : 0;
	localparam int MW   = 64 + LSH;

	// Stage 1: u^2, u(1-u), |1-2u| and span^2.
	logic        valid_s1, e_neg_s1;
	logic [31:0] u_s1, u2_s1, w_s1, e_mag_s1, mag_s1, span_s1, amp_s1;
	logic [63:0] dd_s1;
	ctl_t        ctl_s1;

	logic [63:0] uu, uw;
	logic [32:0] tw;
	logic        e_neg_nx;
	logic [32:0] e_mag_nx;

	assign uu       = u * u;
	assign uw       = u * (ONE_Q31 - u);
	assign tw       = {u, 1'b0};
	assign e_neg_nx = u > (ONE_Q31 >> 1);
	assign e_mag_nx = e_neg_nx ? (tw - {1'b0, ONE_Q31}) : ({1'b0, ONE_Q31} - tw);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1     <= u;
			u2_s1    <= uu[62:31];
			w_s1     <= uw[62:31];
			e_neg_s1 <= e_neg_nx;
			e_mag_s1 <= e_mag_nx[31:0];
			dd_s1    <= span * span;
			mag_s1   <= mag;
			span_s1  <= span;
			amp_s1   <= in_amp;
			ctl_s1   <= in_ctl;
		end
	end

	// Stage 2: 3u^2-2u^3 and the amplitude products.
	logic        valid_s2, e_neg_s2;
	logic [31:0] s_s2, mag_s2, span_s2, amp_s2;
	logic [63:0] pw_s2, pe_s2, dd_s2;
	ctl_t        ctl_s2;

	logic [32:0] cfac;
	logic [64:0] su;

	assign cfac = 33'h1_8000_0000 - {u_s1, 1'b0};
	assign su   = u2_s1 * cfac;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2     <= su[62:31];
			pw_s2    <= mag_s1 * w_s1;
			pe_s2    <= mag_s1 * e_mag_s1;
			e_neg_s2 <= e_neg_s1;
			mag_s2   <= mag_s1;
			span_s2  <= span_s1;
			dd_s2    <= dd_s1;
			amp_s2   <= amp_s1;
			ctl_s2   <= ctl_s1;
		end
	end

	// Stage 3: value magnitude and the scaled division numerators.
	logic           valid_s3, e_neg_s3;
	logic [31:0]    val_s3, span_s3, amp_s3;
	logic [PS_W-1:0] ps_s3;
	logic [MW-1:0]  mc_s3;
	logic [63:0]    dd_s3;
	ctl_t           ctl_s3;

	logic [63:0] vm;
	logic [65:0] p6, m3, p6_sh;
	logic [MW-1:0] mext;

	assign vm    = mag_s2 * s_s2;
	assign p6    = {pw_s2, 2'b00} + {1'b0, pw_s2, 1'b0};
	assign p6_sh = p6 >> K;
	assign m3    = {1'b0, pe_s2, 1'b0} + {2'b00, pe_s2};
	assign mext  = MW'(m3[63:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			val_s3   <= vm[62:31];
			ps_s3    <= p6_sh[PS_W-1:0];
			mc_s3    <= (mext << LSH) >> RSH;
			e_neg_s3 <= e_neg_s2;
			span_s3  <= span_s2;
			dd_s3    <= dd_s2;
			amp_s3   <= amp_s2;
			ctl_s3   <= ctl_s2;
		end
	end

	// Stage 4: overflow checks and divider start values.
	logic [31:0] s_hi;
	logic [63:0] c_hi;
	logic        ovf_s_nx, ovf_c_nx;

	assign s_hi     = 32'(ps_s3[PS_W-1:32]);
	assign c_hi     = 64'(mc_s3[MW-1:32]);
	assign ovf_s_nx = s_hi >= span_s3;
	assign ovf_c_nx = c_hi >= dd_s3;

	logic        valid_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			s_rem   <= ovf_s_nx ? 32'd0 : s_hi;
			s_lo    <= ps_s3[31:0];
			ovf_s   <= ovf_s_nx;
			s_den   <= span_s3;
			c_rem   <= ovf_c_nx ? 64'd0 : c_hi;
			c_lo    <= mc_s3[31:0];
			ovf_c   <= ovf_c_nx;
			c_den   <= dd_s3;
			val_mag <= val_s3;
			e_neg   <= e_neg_s3;
			out_amp <= amp_s3;
			out_ctl <= ctl_s3;
		end
	end

	// Valid bits for all four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign out_valid = valid_s4;

endmodule

@@ hw/rtl/cubic_smoothstep_profile.sv @@
// ----------------------------------------------------------------------------
// cubic_smoothstep_profile
// Takes one Q16.16 position per cycle and returns the smoothstep value, slope
// and curvature, one result per cycle, while the result side is not stalled.
// The pipeline is two 16-stage long dividers in series (position to u, then
// the slope and curvature quotients), with one input stage, four multiplier
// stages and the output register around them. A stall on the result side
// freezes the whole pipeline, so nothing is dropped or repeated.
// Configuration is written directly and takes effect for the next request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cubic_smoothstep_profile_defines.svh"

module cubic_smoothstep_profile import css_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]          wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [31:0]   position,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   value,
	output logic signed [31:0]   slope,
	output logic signed [31:0]   curvature,
	output logic                 bad_span
);

	logic adv;
	assign in_stall = out_valid && out_stall;
	assign adv      = !in_stall;

	// Configuration registers.
	logic signed [31:0] span_start_q, span_end_q, amplitude_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_start_q <= 32'sd0;
			span_end_q   <= 32'sd65536;
			amplitude_q  <= 32'sd65536;
		end else if (wr_en) begin
			case (wr_index)
				REG_SPAN_START: span_start_q <= wr_data;
				REG_SPAN_END:   span_end_q   <= wr_data;
				REG_AMPLITUDE:  amplitude_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Input stage: region flags, offset into the span and amplitude magnitude.
	logic        valid_s1;
	ctl_t        ctl_s1;
	logic [31:0] amp_s1, mag_s1, span_s1, d_s1;

	logic signed [32:0] d_nx;
	ctl_t               ctl_nx;

	assign d_nx         = 33'(position) - 33'(span_start_q);
	assign ctl_nx.bad   = span_end_q <= span_start_q;
	assign ctl_nx.below = position < span_start_q;
	assign ctl_nx.above = position > span_end_q;
	assign ctl_nx.neg   = amplitude_q[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1  <= ctl_nx;
			amp_s1  <= amplitude_q;
			mag_s1  <= amplitude_q[31] ? (~amplitude_q + 32'd1) : amplitude_q;
			span_s1 <= 32'(span_end_q - span_start_q);
			d_s1    <= d_nx[31:0];
		end
	end

	// u = offset * 2^31 / span.
	localparam int U_SIDE_W = $bits(ctl_t) + 96;

	logic                u_valid;
	logic [31:0]         u_quo;
	logic [U_SIDE_W-1:0] u_side;
	ctl_t                u_ctl;
	logic [31:0]         u_amp, u_mag, u_span;

	css_div_pipe #(
		.DEN_W  (32),
		.SIDE_W (U_SIDE_W)
	) u_div_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s1),
		.in_rem    ({1'b0, d_s1[31:1]}),
		.in_lo     ({d_s1[0], 31'd0}),
		.in_den    (span_s1),
		.in_side   ({ctl_s1, amp_s1, mag_s1, span_s1}),
		.out_valid (u_valid),
		.out_quo   (u_quo),
		.out_side  (u_side)
	);

	assign {u_ctl, u_amp, u_mag, u_span} = u_side;

	// Polynomial terms and division numerators.
	logic        p_valid, p_e_neg, p_ovf_s, p_ovf_c;
	ctl_t        p_ctl;
	logic [31:0] p_amp, p_val_mag, p_s_rem, p_s_lo, p_s_den, p_c_lo;
	logic [63:0] p_c_rem, p_c_den;

	css_poly #(
		.FRAC_BITS (FRAC_BITS)
	) u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (u_valid),
		.u         (u_quo),
		.span      (u_span),
		.mag       (u_mag),
		.in_ctl    (u_ctl),
		.in_amp    (u_amp),
		.out_valid (p_valid),
		.out_ctl   (p_ctl),
		.out_amp   (p_amp),
		.val_mag   (p_val_mag),
		.e_neg     (p_e_neg),
		.s_rem     (p_s_rem),
		.s_lo      (p_s_lo),
		.ovf_s     (p_ovf_s),
		.s_den     (p_s_den),
		.c_rem     (p_c_rem),
		.c_lo      (p_c_lo),
		.ovf_c     (p_ovf_c),
		.c_den     (p_c_den)
	);

	// Slope quotient; this divider also carries the request's flags.
	localparam int S_SIDE_W = $bits(ctl_t) + 66;

	logic                sd_valid;
	logic [31:0]         sd_quo;
	logic [S_SIDE_W-1:0] sd_side;
	ctl_t                f_ctl;
	logic [31:0]         f_amp, f_val_mag;
	logic                f_e_neg, f_ovf_s;

	css_div_pipe #(
		.DEN_W  (32),
		.SIDE_W (S_SIDE_W)
	) u_div_slope (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (p_valid),
		.in_rem    (p_s_rem),
		.in_lo     (p_s_lo),
		.in_den    (p_s_den),
		.in_side   ({p_ctl, p_amp, p_val_mag, p_e_neg, p_ovf_s}),
		.out_valid (sd_valid),
		.out_quo   (sd_quo),
		.out_side  (sd_side)
	);

	assign {f_ctl, f_amp, f_val_mag, f_e_neg, f_ovf_s} = sd_side;

	// Curvature quotient over span squared.
	logic        cd_valid;
	logic [31:0] cd_quo;
	logic        f_ovf_c;

	css_div_pipe #(
		.DEN_W  (64),
		.SIDE_W (1)
	) u_div_curv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (p_valid),
		.in_rem    (p_c_rem),
		.in_lo     (p_c_lo),
		.in_den    (p_c_den),
		.in_side   (p_ovf_c),
		.out_valid (cd_valid),
		.out_quo   (cd_quo),
		.out_side  (f_ovf_c)
	);

	// Region selection and saturation.
	logic [31:0] val_nx, slope_nx, curv_nx;

	always_comb begin
		val_nx   = 32'd0;
		slope_nx = 32'd0;
		curv_nx  = 32'd0;
		if (f_ctl.bad) begin
			val_nx = f_ctl.below ? 32'd0 : f_amp;
		end else if (f_ctl.below) begin
			val_nx = 32'd0;
		end else if (f_ctl.above) begin
			val_nx = f_amp;
		end else begin
			val_nx   = sat32(f_ctl.neg, 1'b0, f_val_mag);
			slope_nx = sat32(f_ctl.neg, f_ovf_s, sd_quo);
			curv_nx  = sat32(f_ctl.neg ^ f_e_neg, f_ovf_c, cd_quo);
		end
	end

	// Output register.
	logic               out_valid_q, bad_span_q;
	logic signed [31:0] value_q, slope_q, curvature_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= sd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_q     <= val_nx;
			slope_q     <= slope_nx;
			curvature_q <= curv_nx;
			bad_span_q  <= f_ctl.bad;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign slope     = slope_q;
	assign curvature = curvature_q;
	assign bad_span  = bad_span_q;

	// Checks on the datapath and pipeline control.
	`CSS_ASSERT_IMPL(a_bad_zero, out_valid && bad_span, slope == 32'sd0 && curvature == 32'sd0, "bad span gave a nonzero derivative")
	`CSS_ASSERT_IMPL(a_div_sync, 1'b1, sd_valid == cd_valid, "slope and curvature dividers out of step")
	`CSS_ASSERT_IMPL(a_u_range, u_valid && !u_ctl.bad && !u_ctl.below && !u_ctl.above, u_quo <= ONE_Q31, "u above one inside the span")
	`CSS_ASSERT_NEXT(a_stall_freeze, in_stall, $stable(u_valid) && $stable(sd_valid), "pipeline moved during a stall")

endmodule

@@ tb/cubic_smoothstep_profile_test.sv @@
// ----------------------------------------------------------------------------
// cubic_smoothstep_profile_test
// Drives positions into the smoothstep profile under several span and
// amplitude settings, with random gaps and result-side stalls. A scoreboard
// predicts value, slope, curvature and the bad-span flag of each request
// and checks every result against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cubic_smoothstep_profile_test;
	import css_pkg::*;

	typedef struct {
		logic [31:0] value;
		logic [31:0] slope;
		logic [31:0] curvature;
		logic        bad_span;
	} ramp_point_t;

	// Scoreboard: keeps its own copy of the registers and the ramp math.
	class ramp_scoreboard;
		logic [31:0] start_q = 32'd0;
		logic [31:0] end_q = 32'd65536;
		logic [31:0] amp_q = 32'd65536;
		ramp_point_t pending[$];
		int errors = 0;

		// Clamps a signed magnitude to the 32-bit range.
		function logic [31:0] clamp(bit neg, logic [127:0] mag);
			if (neg) begin
				if (mag > 128'h8000_0000) return 32'h8000_0000;
				return 32'd0 - mag[31:0];
			end
			if (mag > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
			return mag[31:0];
		endfunction

		function ramp_point_t ramp_at(logic [31:0] pos);
			ramp_point_t r;
			longint x, st, en, am;
			logic [127:0] span, d, u, u2, s, w, mag, e_mag, m, q;
			bit neg, e_neg;
			x = longint'(signed'(pos));
			st = longint'(signed'(start_q));
			en = longint'(signed'(end_q));
			am = longint'(signed'(amp_q));
			neg = am < 0;
			mag = neg ? -am : am;
			r.value = 0;
			r.slope = 0;
			r.curvature = 0;
			r.bad_span = 0;
			if (en <= st) begin
				r.bad_span = 1;
				r.value = (x < st) ? 32'd0 : amp_q;
				return r;
			end
			if (x < st) return r;
			if (x > en) begin
				r.value = amp_q;
				return r;
			end
			span = en - st;
			d = x - st;
			u = (d << 31) / span;
			u2 = (u * u) >> 31;
			s = (u2 * (3 * 128'h8000_0000 - 2 * u)) >> 31;
			w = (u * (128'h8000_0000 - u)) >> 31;
			e_neg = (2 * u) > 128'h8000_0000;
			e_mag = e_neg ? (2 * u - 128'h8000_0000) : (128'h8000_0000 - 2 * u);
			m = 3 * mag * e_mag;
			q = ((m << 33) / (span * span)) >> 31;
			r.value = clamp(neg, (mag * s) >> 31);
			r.slope = clamp(neg, (6 * mag * w) / (span << 15));
			r.curvature = clamp(neg != e_neg, q);
			return r;
		endfunction

		function void note_request(logic [31:0] pos);
			pending.push_back(ramp_at(pos));
		endfunction

		function void check_result(logic [31:0] v, logic [31:0] s,
				logic [31:0] c, logic b);
			ramp_point_t e;
			if (pending.size() == 0) begin
				$display("%0t: result with no request pending", $time);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (v !== e.value) begin
				$display("%0t: value expected %h actual %h", $time, e.value, v);
				errors++;
			end
			if (s !== e.slope) begin
				$display("%0t: slope expected %h actual %h", $time, e.slope, s);
				errors++;
			end
			if (c !== e.curvature) begin
				$display("%0t: curvature expected %h actual %h", $time, e.curvature, c);
				errors++;
			end
			if (b !== e.bad_span) begin
				$display("%0t: bad_span expected %b actual %b", $time, e.bad_span, b);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic [CFG_IDX_W-1:0] wr_index = REG_SPAN_START;
	logic [31:0] wr_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] position = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] value, slope, curvature;
	logic bad_span;

	ramp_scoreboard board = new();
	int hold_cycles = 0;
	bit quiet_sink = 0;

	cubic_smoothstep_profile dut (.*);

	always #5 clk = ~clk;

	// Short gaps are common, long ones rare.
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Result side: checks accepted results and stalls at random.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				board.check_result(value, slope, curvature, bad_span);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1;
			end else if (quiet_sink) begin
				out_stall <= 0;
			end else begin
				out_stall <= (pick_gap() > 0);
			end
		end
	end

	// Offers one request and waits until it is taken.
	task send_position(logic [31:0] pos, bit no_gap = 0);
		int gap;
		in_valid <= 1;
		position <= pos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(pos);
		gap = no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One register write; the write port is then idled before the scoreboard copy is updated.
	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 0;
		@(posedge clk);
		case (idx)
			REG_SPAN_START: board.start_q = data;
			REG_SPAN_END:   board.end_q = data;
			default:        board.amp_q = data;
		endcase
	endtask

	// Waits until every expected result has arrived, then lets the pipe settle.
	task drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task set_profile(logic [31:0] st, logic [31:0] en, logic [31:0] am);
		drain();
		write_reg(REG_SPAN_START, st);
		write_reg(REG_SPAN_END, en);
		write_reg(REG_AMPLITUDE, am);
	endtask

	// Positions mostly inside the span, some near its ends, some anywhere.
	function logic [31:0] pick_position();
		longint st, en, p;
		int r;
		st = longint'(signed'(board.start_q));
		en = longint'(signed'(board.end_q));
		r = $urandom_range(0, 9);
		if (r < 3 || en <= st) return $urandom;
		if (r < 4) return board.start_q + $urandom_range(0, 4) - 2;
		if (r < 5) return board.end_q + $urandom_range(0, 4) - 2;
		p = st + longint'({$urandom, $urandom} % (en - st + 1));
		return p[31:0];
	endfunction

	task random_phase(int n);
		repeat (n) send_position(pick_position());
	endtask

	// Main sequence: directed corners, then random phases over several settings.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset profile: ends, just outside, midpoint, quarter point, field extremes.
		send_position(32'sd0);
		send_position(32'sd65536);
		send_position(-32'sd1);
		send_position(32'sd65537);
		send_position(32'sd32768);
		send_position(32'h8000_0000);
		send_position(32'h7FFF_FFFF);
		send_position(32'sd16384);

		// Widest span and most negative amplitude.
		set_profile(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_position(32'h8000_0000);
		send_position(32'h7FFF_FFFF);
		send_position(32'sd0);
		send_position(32'hC000_0000);

		// One-step span: derivatives saturate.
		set_profile(32'sd100, 32'sd101, 32'h7FFF_FFFF);
		send_position(32'sd100);
		send_position(32'sd101);
		send_position(32'sd99);

		// Bad spans: empty and reversed.
		set_profile(32'sd5000, 32'sd5000, 32'sd12345);
		send_position(32'sd4999);
		send_position(32'sd5000);
		send_position(32'sd5001);
		set_profile(32'sd70000, -32'sd70000, -32'sd777);
		send_position(-32'sd80000);
		send_position(32'sd70000);
		random_phase(20);

		// Receiver holds off while requests keep coming, filling the pipe.
		set_profile(-32'sd65536, 32'sd196608, 32'sd327680);
		hold_cycles = 300;
		repeat (80) send_position(pick_position(), 1);
		random_phase(100);

		set_profile(32'sd1000, 32'sd1000 + 32'sd3000, -32'sd65536);
		random_phase(100);
		set_profile($urandom, $urandom, $urandom);
		random_phase(80);
		set_profile(-32'sd10, 32'sd10, 32'h7FFF_FFFF);
		random_phase(60);

		// No stalls on the result side for a stretch.
		set_profile(32'sd0, 32'h4000_0000, 32'h0001_0000);
		quiet_sink = 1;
		random_phase(80);
		quiet_sink = 0;
		set_profile(32'h7FFF_0000, 32'h7FFF_FFFF, 32'h8000_0001);
		random_phase(60);

		drain();
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/css_pkg.sv
hw/rtl/css_div_pipe.sv
hw/rtl/css_poly.sv
hw/rtl/cubic_smoothstep_profile.sv
tb/cubic_smoothstep_profile_test.sv
